@@ rtl/bcc_pkg.sv @@
// Shared types and constants for the battery coulomb counter.
// Holds the measurement and result payload structs, register indexes and widths.
// No dependencies; every other file except bcc_stream_if imports this package.
`default_nettype none

package bcc_pkg;

	// Widths of configuration fields and of the soc division.
	localparam int CAP_W      = 13;
	localparam int SOC_W      = 10;
	localparam int DIVIDEND_W = 23;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Register indexes on the write port.
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SOC_INTERNAL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REST_CURRENT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_VOLTAGE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EMPTY_VOLT   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_REST_DUR     = 3'd5;

	// Register reset values.
	localparam logic [CAP_W-1:0] CAPACITY_RST     = 13'd100;
	localparam logic [9:0]       REST_CURRENT_RST = 10'd1;
	localparam logic [13:0]      FULL_VOLTAGE_RST = 14'd5600;
	localparam logic [13:0]      EMPTY_VOLT_RST   = 14'd4600;
	localparam logic [15:0]      REST_DUR_RST     = 16'd60;

	// One tenth of an ampere hour in ampere milliseconds.
	localparam logic signed [31:0] ACC_STEP = 32'sd360000;
	localparam logic [SOC_W-1:0]   SOC_MAX  = 10'd1000;

	typedef struct packed {
		logic [15:0]        elapsed_ms;
		logic signed [15:0] current_a;
		logic [13:0]        voltage_cv;
		logic [9:0]         reported_soc;
		logic               reported_valid;
	} meas_t;

	typedef struct packed {
		logic [15:0]      charge_dah;
		logic [SOC_W-1:0] soc_permille;
		logic             is_full;
		logic             is_empty;
	} result_t;

endpackage

`default_nettype wire

@@ rtl/bcc_stream_if.sv @@
// Valid/ready stream interface used by the coulomb counter channels.
// The payload type is a parameter; the types come from bcc_pkg.
`default_nettype none

interface bcc_stream_if #(
	parameter type payload_t = logic
) ();

	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);

endinterface

`default_nettype wire

@@ rtl/bcc_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Used for the state-of-charge ratio; depends on bcc_pkg for widths.
`default_nettype none

module bcc_div (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [bcc_pkg::DIVIDEND_W-1:0] dividend,
	input  wire logic [bcc_pkg::CAP_W-1:0]      divisor,
	output logic                                done,
	output logic [bcc_pkg::DIVIDEND_W-1:0]      quotient
);
	import bcc_pkg::*;

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic [CAP_W-1:0]      rem_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [CAP_W:0]        trial;
	logic                  fits;

	// Bring down the next dividend bit and try the subtraction.
	assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
	assign fits  = trial >= {1'b0, divisor};

	// Control: count the quotient bits and flag the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVIDEND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	// Datapath: the dividend shifts out as the quotient shifts in.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? CAP_W'(trial - {1'b0, divisor}) : trial[CAP_W-1:0];
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

@@ rtl/battery_coulomb_counter_top.sv @@
// Battery coulomb counter: sequencer, state registers and configuration.
// Depends on bcc_pkg, bcc_stream_if and the divider bcc_div.
//
// Usage:
//   meas carries one measurement per transaction (elapsed time, current,
//   voltage, reported soc). result carries one result per measurement:
//   charge in 0.1 Ah, soc in 0.1 %, and the full and empty flags.
//   Registers are written on wr_en with wr_index and wr_data; writes take effect
//   at once. The user must write only while no measurement is in flight (unchecked).
// Operation:
//   A measurement goes through multiply, accumulate, update and soc steps.
//   With internal soc and nonzero capacity the soc ratio then runs through
//   the divider at one quotient bit per cycle; otherwise the soc step goes
//   straight to the done state. meas.ready is high only between items, one
//   item is worked on at a time.
// Reset:
//   arst_n clears the accumulator, charge, rest timer and soc, and loads
//   the register defaults. No output is valid after reset.
// Stalls:
//   A finished result waits in the output register until taken. The next
//   measurement may be accepted meanwhile; its result waits for the slot.
`default_nettype none

module battery_coulomb_counter_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	bcc_stream_if.sink                          meas,
	bcc_stream_if.source                        result,
	input  wire logic                           wr_en,
	input  wire logic [bcc_pkg::CFG_IDX_W-1:0]  wr_index,
	input  wire logic [bcc_pkg::CFG_DATA_W-1:0] wr_data
);
	import bcc_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_ACC  = 3'd2;
	localparam logic [2:0] S_UPD  = 3'd3;
	localparam logic [2:0] S_SOC  = 3'd4;
	localparam logic [2:0] S_DIV  = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	// Configuration registers.
	logic [CAP_W-1:0] cap_q;
	logic             soc_int_q;
	logic [9:0]       rest_cur_q;
	logic [13:0]      full_v_q;
	logic [13:0]      empty_v_q;
	logic [15:0]      rest_dur_q;

	// Persistent state.
	logic signed [31:0] accum_q;
	logic [15:0]        charge_q;
	logic [31:0]        ms_q;
	logic [SOC_W-1:0]   soc_q;

	// Per-item working registers.
	logic [2:0]         state_q;
	meas_t              item_q;
	logic signed [33:0] prod_s1;
	logic [32:0]        ms_sum_q;
	logic [25:0]        rest_ms_q;
	logic signed [31:0] acc_sat_q;
	logic               full_q;
	logic               empty_q;
	result_t            res_q;
	logic               res_valid_q;

	logic                  accept;
	logic                  res_load;
	logic signed [33:0]    prod_c;
	logic signed [34:0]    acc_sum_c;
	logic signed [31:0]    acc_sat_c;
	logic [31:0]           ms_sat_c;
	logic [16:0]           cap_dah;
	logic signed [31:0]    acc_next;
	logic [15:0]           charge_next;
	logic                  discharging;
	logic                  div_start;
	logic                  div_done;
	logic [DIVIDEND_W-1:0] div_quo;
	logic [DIVIDEND_W-1:0] dividend;

	assign accept     = meas.valid && meas.ready;
	assign meas.ready = (state_q == S_IDLE);

	// The finished item moves into the output slot once the slot is free or being taken.
	assign res_load = (state_q == S_DONE) && (!res_valid_q || result.ready);

	// Configuration write port; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q      <= CAPACITY_RST;
			soc_int_q  <= 1'b1;
			rest_cur_q <= REST_CURRENT_RST;
			full_v_q   <= FULL_VOLTAGE_RST;
			empty_v_q  <= EMPTY_VOLT_RST;
			rest_dur_q <= REST_DUR_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_CAPACITY:     cap_q      <= wr_data[CAP_W-1:0];
				REG_SOC_INTERNAL: soc_int_q  <= wr_data[0];
				REG_REST_CURRENT: rest_cur_q <= wr_data[9:0];
				REG_FULL_VOLTAGE: full_v_q   <= wr_data[13:0];
				REG_EMPTY_VOLT:   empty_v_q  <= wr_data[13:0];
				REG_REST_DUR:     rest_dur_q <= wr_data;
				default: ;
			endcase
		end
	end

	// Current times elapsed time; 16 by 17 signed fits in 34 bits.
	assign prod_c = $signed(item_q.current_a) * $signed({1'b0, item_q.elapsed_ms});

	// Accumulate and saturate to the signed 32-bit range.
	assign acc_sum_c = 35'(accum_q) + 35'(prod_s1);
	always_comb begin
		if (acc_sum_c[34:31] != {4{acc_sum_c[34]}})
			acc_sat_c = acc_sum_c[34] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		else
			acc_sat_c = acc_sum_c[31:0];
	end

	assign ms_sat_c = ms_sum_q[32] ? '1 : ms_sum_q[31:0];
	assign cap_dah  = 17'(cap_q) * 17'd10;

	// Move at most one 0.1 Ah count, then apply the empty and full overrides.
	always_comb begin
		acc_next    = acc_sat_q;
		charge_next = charge_q;
		if (acc_sat_q > ACC_STEP) begin
			acc_next = acc_sat_q - ACC_STEP;
			if ({1'b0, charge_q} < cap_dah)
				charge_next = charge_q + 16'd1;
		end else if (acc_sat_q < -ACC_STEP) begin
			acc_next = acc_sat_q + ACC_STEP;
			if (charge_q != 16'd0)
				charge_next = charge_q - 16'd1;
		end
		if (empty_q)
			charge_next = '0;
		if (full_q)
			charge_next = cap_dah[15:0];
	end

	assign discharging = $signed({item_q.current_a[15], item_q.current_a}) <=
		-$signed({7'd0, rest_cur_q});

	assign dividend  = 23'(charge_q) * 23'd100;
	assign div_start = (state_q == S_SOC) && soc_int_q && (cap_q != '0);

	bcc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (cap_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Sequencer and state updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			accum_q     <= '0;
			charge_q    <= '0;
			ms_q        <= '0;
			soc_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			// Output slot: filled by the sequencer, emptied by a result transaction.
			if (res_load)
				res_valid_q <= 1'b1;
			else if (result.valid && result.ready)
				res_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept)
						state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					ms_q    <= ms_sat_c;
					state_q <= S_UPD;
				end
				S_UPD: begin
					accum_q  <= acc_next;
					charge_q <= charge_next;
					if (discharging)
						ms_q <= '0;
					state_q <= S_SOC;
				end
				S_SOC: begin
					if (soc_int_q) begin
						if (cap_q == '0) begin
							soc_q   <= '0;
							state_q <= S_DONE;
						end else begin
							state_q <= S_DIV;
						end
					end else begin
						if (item_q.reported_valid)
							soc_q <= (item_q.reported_soc > SOC_MAX) ?
								SOC_MAX : item_q.reported_soc;
						state_q <= S_DONE;
					end
				end
				S_DIV: begin
					if (div_done) begin
						soc_q   <= (div_quo > DIVIDEND_W'(SOC_MAX)) ?
							SOC_MAX : div_quo[SOC_W-1:0];
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload registers for the item in flight and the output slot.
	always_ff @(posedge clk) begin
		if (accept)
			item_q <= meas.payload;
		if (state_q == S_MUL) begin
			prod_s1   <= prod_c;
			ms_sum_q  <= {1'b0, ms_q} + 33'(item_q.elapsed_ms);
			rest_ms_q <= 26'(rest_dur_q) * 26'd1000;
		end
		if (state_q == S_ACC) begin
			acc_sat_q <= acc_sat_c;
			empty_q   <= (item_q.voltage_cv <= empty_v_q) &&
				(ms_sat_c > 32'(rest_ms_q));
			full_q    <= (item_q.voltage_cv >= full_v_q) &&
				(item_q.current_a < $signed({6'd0, rest_cur_q}));
		end
		if (res_load) begin
			res_q.charge_dah   <= charge_q;
			res_q.soc_permille <= soc_q;
			res_q.is_full      <= full_q;
			res_q.is_empty     <= empty_q;
		end
	end

	assign result.valid   = res_valid_q;
	assign result.payload = res_q;

endmodule

`default_nettype wire

@@ rtl/bcc_checker.sv @@
// Port-level checks for the battery coulomb counter, bound to the top level.
// Depends on bcc_pkg for the result type.
`default_nettype none

module bcc_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             meas_valid,
	input wire logic             meas_ready,
	input wire logic             result_valid,
	input wire logic             result_ready,
	input wire bcc_pkg::result_t result_payload
);
	import bcc_pkg::*;

	// A stalled result holds its transaction.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_payload))
		else $error("result changed while stalled");

	// The block works on one measurement at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		meas_valid && meas_ready |=> !meas_ready)
		else $error("measurement accepted while another is in flight");

	// Soc never exceeds 100 %.
	a_soc_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result_payload.soc_permille <= SOC_MAX)
		else $error("soc above 1000");

	// Empty without full forces the charge to zero.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_payload.is_empty && !result_payload.is_full |->
		result_payload.charge_dah == 16'd0)
		else $error("empty result with nonzero charge");

endmodule

bind battery_coulomb_counter_top bcc_checker u_bcc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.meas_valid     (meas.valid),
	.meas_ready     (meas.ready),
	.result_valid   (result.valid),
	.result_ready   (result.ready),
	.result_payload (result.payload)
);

`default_nettype wire

@@ bench/tb_battery_coulomb_counter_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for battery_coulomb_counter_top: directed table, random phases, soak.
// Depends on bcc_pkg, bcc_stream_if and the counter RTL; results are checked by a local predictor.

module tb_battery_coulomb_counter_top;

	import bcc_pkg::*;

	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int RANDOM_PHASES   = 6;
	localparam int ITEMS_PER_PHASE = 130;
	localparam int SOAK_ITEMS      = 50;
	localparam int DRAIN_CYCLES    = 40;
	localparam int SETTLE_CYCLES   = 4;

	localparam longint      ACC_HI    = 64'sd2147483647;
	localparam longint      ACC_LO    = -64'sd2147483648;
	localparam int unsigned TIMER_MAX = 32'hFFFF_FFFF;

	// Indexes with no register behind them; writes there must be ignored.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_7 = 3'd7;

	typedef enum logic {ROW_MEAS, ROW_WRITE} row_kind_e;
	typedef enum int {CHARGING, DISCHARGING, RESTING, TOPPING, NOISE} regime_e;

	typedef struct packed {
		row_kind_e               kind;
		logic [CFG_IDX_W-1:0]    idx;
		logic [CFG_DATA_W-1:0]   data;
		meas_t                   m;
		bit                      known;
		result_t                 want;
	} plan_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	bcc_stream_if #(.payload_t(meas_t))   meas_ch ();
	bcc_stream_if #(.payload_t(result_t)) result_ch ();

	battery_coulomb_counter_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.meas     (meas_ch),
		.result   (result_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// Predicted counter state and register copies.
	int          acc_ms;
	int unsigned charge_dah_m;
	int unsigned rest_ms;
	logic [SOC_W-1:0] soc_m;
	int unsigned cap_ah;
	bit          soc_from_charge;
	int unsigned rest_cur_a;
	int unsigned full_cv;
	int unsigned empty_cv;
	int unsigned rest_s;

	result_t   expected_q[$];
	plan_row_t plan[$];

	int tx_idle_pct = 29;
	int rx_idle_pct = 50;
	int n_meas      = 0;
	int n_checked   = 0;
	int n_errors    = 0;
	int n_settings  = 0;
	int quiet_cycles = 0;

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// One measurement through the coulomb counter: accumulate, move a count,
	// detect full and empty, then update soc and the rest timer.
	function automatic result_t predict_count(meas_t m);
		longint      acc;
		int          cur;
		int unsigned cap_dah;
		int unsigned ratio;
		bit          full;
		bit          empty;
		result_t     r;
		cur = int'($signed(m.current_a));
		acc = longint'(acc_ms) + longint'(cur) * longint'(m.elapsed_ms);
		if (acc > ACC_HI) acc = ACC_HI;
		if (acc < ACC_LO) acc = ACC_LO;
		cap_dah = cap_ah * 10;

		// At most one 0.1 Ah count per measurement; the accumulator moves even when clamped.
		if (acc > longint'(ACC_STEP)) begin
			if (charge_dah_m < cap_dah) charge_dah_m++;
			acc -= longint'(ACC_STEP);
		end else if (acc < -longint'(ACC_STEP)) begin
			if (charge_dah_m > 0) charge_dah_m--;
			acc += longint'(ACC_STEP);
		end
		acc_ms = int'(acc);

		// The rest timer saturates rather than wrapping.
		if (rest_ms > TIMER_MAX - m.elapsed_ms) rest_ms = TIMER_MAX;
		else rest_ms += m.elapsed_ms;

		// Full wins over empty when both hold.
		empty = (m.voltage_cv <= empty_cv) && (rest_ms > rest_s * 1000);
		full = (m.voltage_cv >= full_cv) && (cur < int'(rest_cur_a));
		if (empty) charge_dah_m = 0;
		if (full) charge_dah_m = cap_dah;
		charge_dah_m &= 32'hFFFF;

		if (soc_from_charge) begin
			ratio = (cap_ah != 0) ? charge_dah_m * 100 / cap_ah : 0;
			soc_m = (ratio > SOC_MAX) ? SOC_MAX : ratio[SOC_W-1:0];
		end else if (m.reported_valid) begin
			soc_m = (m.reported_soc > SOC_MAX) ? SOC_MAX : m.reported_soc;
		end

		if (cur <= -int'(rest_cur_a)) rest_ms = 0;

		r.charge_dah   = charge_dah_m[15:0];
		r.soc_permille = soc_m;
		r.is_full      = full;
		r.is_empty     = empty;
		return r;
	endfunction

	function automatic meas_t make_meas(int e, int c, int v, int rs, int rv);
		meas_t m;
		m.elapsed_ms     = e[15:0];
		m.current_a      = c[15:0];
		m.voltage_cv     = v[13:0];
		m.reported_soc   = rs[9:0];
		m.reported_valid = rv[0];
		return m;
	endfunction

	function automatic plan_row_t meas_row(int e, int c, int v, int rs, int rv, bit known,
			result_t want);
		plan_row_t r;
		r       = '0;
		r.kind  = ROW_MEAS;
		r.m     = make_meas(e, c, v, rs, rv);
		r.known = known;
		r.want  = want;
		return r;
	endfunction

	function automatic plan_row_t write_row(logic [CFG_IDX_W-1:0] idx,
			logic [CFG_DATA_W-1:0] data);
		plan_row_t r;
		r      = '0;
		r.kind = ROW_WRITE;
		r.idx  = idx;
		r.data = data;
		return r;
	endfunction

	// Random measurement shaped by the current operating regime.
	function automatic meas_t random_meas(regime_e regime);
		int e;
		int c;
		int v;
		case (regime)
			CHARGING: begin
				e = $urandom_range(20000, 65535);
				c = $urandom_range(1, 32767);
				v = $urandom_range(0, 10000);
			end
			DISCHARGING: begin
				e = $urandom_range(20000, 65535);
				c = -1 - int'($urandom_range(0, 32767));
				v = $urandom_range(0, 10000);
			end
			RESTING: begin
				e = $urandom_range(0, 65535);
				c = int'($urandom_range(0, 40)) - 20;
				v = $urandom_range(0, 5000);
			end
			TOPPING: begin
				e = $urandom_range(0, 65535);
				c = int'($urandom_range(0, 35)) - 5;
				v = $urandom_range(5000, 10000);
			end
			default: begin
				e = $urandom_range(0, 65535);
				c = $urandom_range(0, 65535);
				v = $urandom_range(0, 16383);
			end
		endcase
		return make_meas(e, c, v, $urandom_range(0, 1023), $urandom_range(0, 1));
	endfunction

	// Low extreme in the first phase, high extreme in the second, mostly typical after.
	function automatic int pick_setting(int phase, int lo, int hi, int typ_lo, int typ_hi);
		int roll;
		roll = $urandom_range(0, 9);
		if (phase == 0 || (phase > 1 && roll == 0)) return lo;
		if (phase == 1 || roll == 1) return hi;
		return $urandom_range(typ_lo, typ_hi);
	endfunction

	// Drive one measurement and record what it should produce once accepted.
	task automatic send_meas(meas_t m, bit known, result_t want);
		result_t pred;
		@(negedge clk);
		if ($urandom_range(99) < tx_idle_pct) begin
			meas_ch.valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		meas_ch.payload <= m;
		meas_ch.valid   <= 1'b1;
		do @(posedge clk); while (!meas_ch.ready);
		pred = predict_count(m);
		expected_q.push_back(known ? want : pred);
		n_meas++;
	endtask

	// Stop sending and wait until every result has come back.
	task automatic settle(int extra);
		@(negedge clk);
		meas_ch.valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(posedge clk);
		case (idx)
			REG_CAPACITY:     cap_ah = data[CAP_W-1:0];
			REG_SOC_INTERNAL: soc_from_charge = data[0];
			REG_REST_CURRENT: rest_cur_a = data[9:0];
			REG_FULL_VOLTAGE: full_cv = data[13:0];
			REG_EMPTY_VOLT:   empty_cv = data[13:0];
			REG_REST_DUR:     rest_s = data[15:0];
			default: ;
		endcase
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	// Result sink with random back-pressure.
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Compare each result transaction with the oldest prediction.
	always @(posedge clk) begin : check_results
		result_t want;
		if (result_ch.valid && result_ch.ready) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result: charge=%0d soc=%0d full=%0b empty=%0b", $time,
					result_ch.payload.charge_dah, result_ch.payload.soc_permille,
					result_ch.payload.is_full, result_ch.payload.is_empty);
				n_errors++;
			end else begin
				want = expected_q.pop_front();
				n_checked++;
				if (result_ch.payload !== want) begin
					$display("%0t: mismatch: expected charge=%0d soc=%0d full=%0b empty=%0b, got charge=%0d soc=%0d full=%0b empty=%0b",
						$time, want.charge_dah, want.soc_permille, want.is_full, want.is_empty,
						result_ch.payload.charge_dah, result_ch.payload.soc_permille,
						result_ch.payload.is_full, result_ch.payload.is_empty);
					n_errors++;
				end
			end
		end
	end

	// Watchdog on cycles with no transaction at all.
	always @(posedge clk) begin
		if (!arst_n || wr_en || (meas_ch.valid && meas_ch.ready) ||
				(result_ch.valid && result_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin : stimulus
		regime_e regime;
		int      run_left;

		// Known inputs and reset state of the predictor.
		arst_n          = 1'b0;
		wr_en           = 1'b0;
		wr_index        = '0;
		wr_data         = '0;
		meas_ch.valid   = 1'b0;
		meas_ch.payload = '0;
		acc_ms          = 0;
		charge_dah_m    = 0;
		rest_ms         = 0;
		soc_m           = '0;
		cap_ah          = CAPACITY_RST;
		soc_from_charge = 1'b1;
		rest_cur_a      = REST_CURRENT_RST;
		full_cv         = FULL_VOLTAGE_RST;
		empty_cv        = EMPTY_VOLT_RST;
		rest_s          = REST_DUR_RST;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed table: state after reset, field extremes and corner cases.
		plan.push_back(meas_row(0, 0, 5000, 0, 0, 1'b1, '{16'd0, 10'd0, 1'b0, 1'b0}));
		plan.push_back(meas_row(0, -32768, 10000, 1023, 1, 1'b1,
			'{16'd1000, 10'd1000, 1'b1, 1'b0}));
		plan.push_back(meas_row(65535, 0, 0, 0, 0, 1'b1, '{16'd0, 10'd0, 1'b0, 1'b1}));
		// Accumulator saturation in both directions.
		plan.push_back(meas_row(65535, 32767, 5000, 0, 0, 1'b0, '0));
		plan.push_back(meas_row(65535, 32767, 5000, 0, 0, 1'b0, '0));
		plan.push_back(meas_row(65535, -32768, 5000, 0, 0, 1'b0, '0));
		plan.push_back(meas_row(65535, -32768, 5000, 0, 0, 1'b0, '0));
		plan.push_back(meas_row(65535, -32768, 5000, 0, 0, 1'b0, '0));
		plan.push_back(meas_row(1, 1, 5000, 0, 0, 1'b0, '0));
		// Reported soc: in range, above 1000, held without a valid report.
		plan.push_back(write_row(REG_SOC_INTERNAL, 16'd0));
		plan.push_back(meas_row(10, 0, 5000, 1000, 1, 1'b0, '0));
		plan.push_back(meas_row(10, 0, 5000, 1023, 1, 1'b0, '0));
		plan.push_back(meas_row(10, 0, 5000, 0, 0, 1'b0, '0));
		plan.push_back(meas_row(10, 0, 5000, 512, 1, 1'b0, '0));
		// Zero capacity keeps charge and soc at zero even when full.
		plan.push_back(write_row(REG_SOC_INTERNAL, 16'd1));
		plan.push_back(write_row(REG_CAPACITY, 16'd0));
		plan.push_back(meas_row(0, -32768, 10000, 0, 0, 1'b1, '{16'd0, 10'd0, 1'b1, 1'b0}));
		plan.push_back(write_row(REG_CAPACITY, 16'd6553));
		plan.push_back(meas_row(0, -32768, 10000, 0, 0, 1'b1,
			'{16'd65530, 10'd1000, 1'b1, 1'b0}));
		// Charge left above a lowered capacity; soc saturates.
		plan.push_back(write_row(REG_CAPACITY, 16'd1));
		plan.push_back(meas_row(0, 0, 5000, 0, 0, 1'b0, '0));
		plan.push_back(write_row(REG_UNUSED_6, 16'hFFFF));
		plan.push_back(write_row(REG_UNUSED_7, 16'hFFFF));
		// Full and empty at once: full wins, both flags set.
		plan.push_back(write_row(REG_FULL_VOLTAGE, 16'd0));
		plan.push_back(write_row(REG_EMPTY_VOLT, 16'd10000));
		plan.push_back(write_row(REG_REST_DUR, 16'd0));
		plan.push_back(write_row(REG_REST_CURRENT, 16'd1000));
		plan.push_back(meas_row(1, 999, 10000, 0, 0, 1'b1, '{16'd10, 10'd1000, 1'b1, 1'b1}));
		// Zero rest current: a zero current clears the timer but is not below it.
		plan.push_back(write_row(REG_REST_CURRENT, 16'd0));
		plan.push_back(meas_row(100, 0, 5000, 0, 0, 1'b1, '{16'd0, 10'd0, 1'b0, 1'b1}));

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WRITE) begin
				settle(SETTLE_CYCLES);
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				send_meas(plan[i].m, plan[i].known, plan[i].want);
			end
		end

		// Random phases: new register settings each phase, regimes held for short runs.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			settle(SETTLE_CYCLES);
			tx_idle_pct = (p < 2) ? 29 : (p < 4) ? 50 : 0;
			rx_idle_pct = (p < 2) ? 50 : (p < 4) ? 29 : 0;
			write_reg(REG_CAPACITY, CFG_DATA_W'(pick_setting(p, 1, 6553, 1, 40)));
			write_reg(REG_SOC_INTERNAL, CFG_DATA_W'(p % 3 != 2));
			write_reg(REG_REST_CURRENT, CFG_DATA_W'(pick_setting(p, 0, 1000, 0, 20)));
			write_reg(REG_FULL_VOLTAGE, CFG_DATA_W'(pick_setting(p, 0, 10000, 5000, 7000)));
			write_reg(REG_EMPTY_VOLT, CFG_DATA_W'(pick_setting(p, 0, 10000, 3000, 5000)));
			write_reg(REG_REST_DUR, CFG_DATA_W'(pick_setting(p, 0, 65535, 0, 120)));
			n_settings++;
			run_left = 0;
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				if (run_left == 0) begin
					regime   = regime_e'($urandom_range(int'(NOISE)));
					run_left = $urandom_range(3, 30);
				end
				run_left--;
				send_meas(random_meas(regime), 1'b0, '0);
			end
		end

		// Long rest at low voltage under the longest rest duration: the timer keeps climbing.
		settle(SETTLE_CYCLES);
		write_reg(REG_SOC_INTERNAL, 16'd0);
		write_reg(REG_REST_CURRENT, 16'd1);
		write_reg(REG_FULL_VOLTAGE, 16'd10000);
		write_reg(REG_EMPTY_VOLT, 16'd10000);
		write_reg(REG_REST_DUR, 16'd65535);
		n_settings++;
		repeat (SOAK_ITEMS) send_meas(make_meas(65535, 0, 0, 0, 0), 1'b0, '0);

		settle(DRAIN_CYCLES);
		$display("Checked %0d results from %0d measurements under %0d register settings,",
			n_checked, n_meas, n_settings);
		$display("including a %0d-measurement long rest run at low voltage.", SOAK_ITEMS);
		if (n_errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/bcc_pkg.sv
rtl/bcc_stream_if.sv
rtl/bcc_div.sv
rtl/battery_coulomb_counter_top.sv
rtl/bcc_checker.sv
bench/tb_battery_coulomb_counter_top.sv
